@@ hw/rtl/dchs_pkg.sv @@
// package for the data channel hop selector
// holds field widths, command codes, controller states and control/status structs
// no dependencies
`default_nettype none

package dchs_pkg;

  localparam int MAP_W     = 37;  // width of the channel map field
  localparam int CMD_W     = 2;
  localparam int INC_W     = 6;
  localparam int CHAN_W    = 6;
  localparam int CNT_OUT_W = 6;

  localparam logic [INC_W-1:0] INC_RESET = 6'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_MAP   = 2'd1,
    CMD_HOP   = 2'd2
  } cmd_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOD_N,
    S_CHECK,
    S_MOD_C,
    S_READ,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_map;
    logic clr_pos;
    logic scan_step;
    logic sum_load;       // load hop position plus increment
    logic sum_step;       // subtract the channel count once
    logic mod_start;      // unmapped mod used count
    logic take_unmapped;
    logic take_direct;
    logic ram_rd;
    logic take_ram;
    logic emit;
  } dchs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic sum_ge;
    logic mod_done;
    logic direct;
  } dchs_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/data_channel_hop_select.sv @@
// top level of the data channel hop selector (channel selection algorithm 1)
// depends on dchs_pkg, dchs_ctrl, dchs_dp
// usage:
//   a transaction is taken when start is high and busy is low. in_command
//   selects start-with-map, apply-map or hop; in_channel_map carries the map.
//   cfg_wr_en/cfg_wr_data write the hop increment; the user must write it
//   while idle (not enforced). every transaction gives exactly one result,
//   shown for one cycle with out_valid; the receiver cannot stall it.
// sequence, accepting edge to out_valid:
//   map commands walk all NUM_CHANNELS channels, one channel per cycle.
//   a hop subtracts NUM_CHANNELS from position plus increment once per cycle
//   until it is below (once at most for increments up to 36); a used channel
//   is taken directly, a remap adds the bit-serial remainder by the
//   used count (6 bits at 37 channels) and a table read.
//   an unknown command goes straight to reporting the current state.
//   busy drops in the cycle out_valid rises; the next transaction may be
//   taken in that same cycle.
// reset:
//   synchronous; hop position and last channel clear, all channels are used,
//   the hop increment returns to 5. the used table needs no clearing.
`default_nettype none

module data_channel_hop_select
  import dchs_pkg::*;
#(
  parameter int NUM_CHANNELS = 37
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [MAP_W-1:0]     in_channel_map,
  input  wire logic                 cfg_wr_en,
  input  wire logic [INC_W-1:0]     cfg_wr_data,
  output logic                      out_valid,
  output logic      [CHAN_W-1:0]    out_channel,
  output logic      [CNT_OUT_W-1:0] out_used_count,
  output logic                      out_map_fallback
);

  dchs_cmd_t cmd;
  dchs_sts_t sts;

  dchs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  dchs_dp #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_channel_map   (in_channel_map),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_channel      (out_channel),
    .out_used_count   (out_used_count),
    .out_map_fallback (out_map_fallback)
  );

endmodule

`default_nettype wire

@@ hw/rtl/dchs_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module dchs_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 37
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/dchs_mod.sv @@
// iterative remainder unit, restoring, one dividend bit per cycle
// no dependencies
`default_nettype none

module dchs_mod #(
  parameter int DVD_W = 7,
  parameter int DVS_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVS_W-1:0] remainder
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic [DVS_W-1:0]  rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = diff[DVS_W-1:0];
    end else begin
      rem_nxt = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ hw/rtl/dchs_dp.sv @@
// datapath: link state, map scan, used channel table, remainder unit, result registers
// depends on dchs_pkg, dchs_ram, dchs_mod
`default_nettype none

module dchs_dp
  import dchs_pkg::*;
#(
  parameter int NUM_CHANNELS = 37
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dchs_cmd_t            cmd,
  output dchs_sts_t                 sts,
  input  wire logic [MAP_W-1:0]     in_channel_map,
  input  wire logic                 cfg_wr_en,
  input  wire logic [INC_W-1:0]     cfg_wr_data,
  output logic                      out_valid,
  output logic      [CHAN_W-1:0]    out_channel,
  output logic      [CNT_OUT_W-1:0] out_used_count,
  output logic                      out_map_fallback
);

  localparam int AW   = $clog2(NUM_CHANNELS);
  localparam int CNTW = $clog2(NUM_CHANNELS + 1);
  localparam int MW   = (NUM_CHANNELS > MAP_W) ? NUM_CHANNELS : MAP_W;
  localparam int SW   = ((AW > INC_W) ? AW : INC_W) + 1;

  logic [INC_W-1:0]        inc_r;
  logic [AW-1:0]           pos_r;
  logic [NUM_CHANNELS-1:0] used_map_r;
  logic [CNTW-1:0]         count_r;
  logic [AW-1:0]           last_r;
  logic [AW-1:0]           unmapped_r;
  logic [SW-1:0]           sum_r;
  logic [NUM_CHANNELS-1:0] scan_map_r;
  logic [AW-1:0]           idx_r;
  logic [CNTW-1:0]         fill_r;
  logic [CNTW-1:0]         fill_nxt;

  logic                    out_valid_r;
  logic [CHAN_W-1:0]       out_channel_r;
  logic [CNT_OUT_W-1:0]    out_count_r;
  logic                    out_fallback_r;

  logic [MW-1:0]           map_wide;
  logic [NUM_CHANNELS-1:0] map_masked;
  logic                    sum_ge;
  logic                    mod_done;
  logic [CNTW-1:0]         mod_rem;
  logic [AW-1:0]           ram_rdata;
  logic                    scan_bit;
  logic                    scan_last;

  assign map_wide   = MW'(in_channel_map);
  assign map_masked = map_wide[NUM_CHANNELS-1:0];

  assign scan_bit  = scan_map_r[0];
  assign scan_last = (idx_r == AW'(NUM_CHANNELS - 1));
  assign fill_nxt  = fill_r + CNTW'(scan_bit);

  // position plus increment is brought below the channel count by subtraction
  assign sum_ge = (sum_r >= SW'(NUM_CHANNELS));

  dchs_mod #(
    .DVD_W (AW),
    .DVS_W (CNTW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mod_start),
    .dividend  (unmapped_r),
    .divisor   (count_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  dchs_ram #(
    .WIDTH (AW),
    .DEPTH (NUM_CHANNELS)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.scan_step && scan_bit),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (idx_r),
    .rd_en   (cmd.ram_rd),
    .rd_addr (mod_rem[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r      <= INC_RESET;
      pos_r      <= '0;
      used_map_r <= '1;
      count_r    <= CNTW'(NUM_CHANNELS);
      last_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        inc_r <= cfg_wr_data;
      end
      if (cmd.latch_map) begin
        used_map_r <= map_masked;
      end
      if (cmd.clr_pos) begin
        pos_r <= '0;
      end else if (cmd.take_unmapped) begin
        pos_r <= sum_r[AW-1:0];
      end
      // empty map falls back to every channel
      if (cmd.scan_step && scan_last) begin
        count_r <= (fill_nxt == '0) ? CNTW'(NUM_CHANNELS) : fill_nxt;
      end
      if (cmd.take_direct) begin
        last_r <= unmapped_r;
      end else if (cmd.take_ram) begin
        last_r <= ram_rdata;
      end
    end
  end

  // scan and hop working registers
  always_ff @(posedge clk) begin
    if (cmd.latch_map) begin
      scan_map_r <= map_masked;
      idx_r      <= '0;
      fill_r     <= '0;
    end else if (cmd.scan_step) begin
      scan_map_r <= scan_map_r >> 1;
      idx_r      <= idx_r + 1'b1;
      fill_r     <= fill_nxt;
    end
    if (cmd.sum_load) begin
      sum_r <= SW'(pos_r) + SW'(inc_r);
    end else if (cmd.sum_step) begin
      sum_r <= sum_r - SW'(NUM_CHANNELS);
    end
    if (cmd.take_unmapped) begin
      unmapped_r <= sum_r[AW-1:0];
    end
  end

  // result registers, strobe lasts one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_channel_r  <= CHAN_W'(last_r);
      out_count_r    <= CNT_OUT_W'(count_r);
      out_fallback_r <= ~|used_map_r;
    end
  end

  // a hop on a used channel or under fallback needs no table lookup
  assign sts.scan_last = scan_last;
  assign sts.sum_ge    = sum_ge;
  assign sts.mod_done  = mod_done;
  assign sts.direct    = used_map_r[unmapped_r] || (used_map_r == '0);

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_used_count   = out_count_r;
  assign out_map_fallback = out_fallback_r;

endmodule

`default_nettype wire

@@ hw/rtl/dchs_ctrl.sv @@
// controller state machine: sequences map scans and hops, drives the datapath
// depends on dchs_pkg
`default_nettype none

module dchs_ctrl
  import dchs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire dchs_sts_t        sts,
  output dchs_cmd_t             cmd,
  output logic                  busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_START: begin
              cmd.latch_map = 1'b1;
              cmd.clr_pos   = 1'b1;
              state_nxt     = S_SCAN;
            end
            CMD_MAP: begin
              cmd.latch_map = 1'b1;
              state_nxt     = S_SCAN;
            end
            CMD_HOP: begin
              cmd.sum_load = 1'b1;
              state_nxt    = S_MOD_N;
            end
            default: begin
              // unknown command reports current state only
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_MOD_N: begin
        if (sts.sum_ge) begin
          cmd.sum_step = 1'b1;
        end else begin
          cmd.take_unmapped = 1'b1;
          state_nxt         = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.direct) begin
          cmd.take_direct = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD_C;
        end
      end
      S_MOD_C: begin
        if (sts.mod_done) begin
          cmd.ram_rd = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.take_ram = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/dchs_chk.sv @@
// port-level checker for the data channel hop selector, bound to the top level
// depends on dchs_pkg
`default_nettype none

module dchs_chk
  import dchs_pkg::*;
#(
  parameter int NUM_CHANNELS = 37
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire logic [CHAN_W-1:0]    out_channel,
  input wire logic [CNT_OUT_W-1:0] out_used_count,
  input wire logic                 out_map_fallback
);

  // a taken transaction raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // results never come in back-to-back cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // finishing a transaction always delivers its result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_channel < CHAN_W'(NUM_CHANNELS)) || (NUM_CHANNELS > CHAN_W'('1)))
    else $error("channel out of range");

  // fallback means the used count covers every channel
  a_fallback_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_map_fallback |-> out_used_count == CNT_OUT_W'(NUM_CHANNELS))
    else $error("fallback with wrong used count");

endmodule

bind data_channel_hop_select dchs_chk #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_dchs_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_channel      (out_channel),
  .out_used_count   (out_used_count),
  .out_map_fallback (out_map_fallback)
);

`default_nettype wire

@@ test/dchs_sel_checker.sv @@
// checker for the data channel hop selector: watches the command, config and result ports
// keeps its own copy of the selector state and compares every result; depends on dchs_pkg
`timescale 1ns / 100ps

module dchs_sel_checker
  import dchs_pkg::*;
#(
  parameter int NUM_CHANNELS = 37
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [MAP_W-1:0]     in_channel_map,
  input  logic                 cfg_wr_en,
  input  logic [INC_W-1:0]     cfg_wr_data,
  input  logic                 out_valid,
  input  logic [CHAN_W-1:0]    out_channel,
  input  logic [CNT_OUT_W-1:0] out_used_count,
  input  logic                 out_map_fallback,
  output int                   fail_count,
  output int                   pending
);

  localparam logic [MAP_W-1:0] CHAN_MASK = {MAP_W{1'b1}} >> (MAP_W - NUM_CHANNELS);

  typedef struct packed {
    logic [CHAN_W-1:0]    channel;
    logic [CNT_OUT_W-1:0] used_count;
    logic                 fallback;
  } sel_result_t;

  // selector state as seen from outside
  logic [INC_W-1:0]  m_hop_inc;
  int                m_hop_pos;
  logic [MAP_W-1:0]  m_used_map;
  logic [CHAN_W-1:0] m_table [0:63];
  int                m_count;
  logic [CHAN_W-1:0] m_last;

  sel_result_t sel_results_q [$];
  int n_fail = 0;
  int n_pend = 0;

  assign fail_count = n_fail;
  assign pending    = n_pend;

  function automatic void reset_selector();
    m_hop_inc  = INC_RESET;
    m_hop_pos  = 0;
    m_used_map = CHAN_MASK;
    for (int i = 0; i < 64; i++) m_table[i] = CHAN_W'(i);
    m_count = NUM_CHANNELS;
    m_last  = '0;
  endfunction

  function automatic void build_used_table(input logic [MAP_W-1:0] map);
    m_used_map = map & CHAN_MASK;
    m_count = 0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (m_used_map[i]) begin
        m_table[m_count] = CHAN_W'(i);
        m_count++;
      end
    end
    // empty map: every channel goes in the table
    if (m_count == 0) begin
      for (int i = 0; i < NUM_CHANNELS; i++) m_table[i] = CHAN_W'(i);
      m_count = NUM_CHANNELS;
    end
  endfunction

  function automatic void hop_once();
    int unmapped;
    unmapped  = (m_hop_pos + int'(m_hop_inc)) % NUM_CHANNELS;
    m_hop_pos = unmapped;
    if (m_used_map[unmapped]) begin
      m_last = CHAN_W'(unmapped);
    end else begin
      m_last = m_table[unmapped % m_count];
    end
  endfunction

  function automatic sel_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                input logic [MAP_W-1:0] map);
    sel_result_t r;
    case (cmd)
      CMD_START: begin
        build_used_table(map);
        m_hop_pos = 0;
      end
      CMD_MAP: begin
        build_used_table(map);
      end
      CMD_HOP: begin
        hop_once();
      end
      default: begin
      end
    endcase
    r.channel    = m_last;
    r.used_count = CNT_OUT_W'(m_count);
    r.fallback   = (m_used_map == '0);
    return r;
  endfunction

  always @(posedge clk) begin
    sel_result_t want;
    if (!rst_n) begin
      reset_selector();
      sel_results_q.delete();
      n_pend <= 0;
    end else begin
      if (out_valid) begin
        if (sel_results_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result with no transaction pending: ch %0d cnt %0d fb %0b",
                     $realtime, out_channel, out_used_count, out_map_fallback);
        end else begin
          want = sel_results_q.pop_front();
          if (out_channel !== want.channel || out_used_count !== want.used_count ||
              out_map_fallback !== want.fallback) begin
            n_fail++;
            if (n_fail <= 10)
              $display("%0t: mismatch ch exp %0d got %0d, cnt exp %0d got %0d, fb exp %0b got %0b",
                       $realtime, want.channel, out_channel, want.used_count,
                       out_used_count, want.fallback, out_map_fallback);
          end
        end
      end
      // config is only written while idle, so it applies to the next transaction
      if (cfg_wr_en) m_hop_inc = cfg_wr_data;
      if (start && !busy) sel_results_q.push_back(apply_command(in_command, in_channel_map));
      n_pend <= sel_results_q.size();
    end
  end

endmodule

@@ test/tb_data_channel_hop_select.sv @@
// testbench top for data_channel_hop_select: clock, reset, command and config stimulus
// depends on dchs_pkg, data_channel_hop_select and dchs_sel_checker
`timescale 1ns / 100ps

module tb_data_channel_hop_select;
  import dchs_pkg::*;

  localparam int NUM_CHANNELS = 37;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_command;
  logic [MAP_W-1:0]     in_channel_map;
  logic                 cfg_wr_en;
  logic [INC_W-1:0]     cfg_wr_data;
  logic                 out_valid;
  logic [CHAN_W-1:0]    out_channel;
  logic [CNT_OUT_W-1:0] out_used_count;
  logic                 out_map_fallback;
  int                   fail_count;
  int                   pending;

  int cycle_cnt = 0;
  bit gaps_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  data_channel_hop_select #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_channel_map  (in_channel_map),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_channel     (out_channel),
    .out_used_count  (out_used_count),
    .out_map_fallback(out_map_fallback)
  );

  dchs_sel_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_channel_map  (in_channel_map),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_channel     (out_channel),
    .out_used_count  (out_used_count),
    .out_map_fallback(out_map_fallback),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // returns right after the accepting edge with start still high
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [MAP_W-1:0] map);
    while (gaps_on && $urandom_range(99) < 7) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_channel_map <= map;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_hop_inc(input logic [INC_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [MAP_W-1:0] rand_map();
    logic [MAP_W-1:0] a, b, c;
    a = MAP_W'({$urandom, $urandom});
    b = MAP_W'({$urandom, $urandom});
    c = MAP_W'({$urandom, $urandom});
    case ($urandom_range(9))
      0:       return '0;
      1:       return {{(MAP_W-1){1'b0}}, 1'b1} << $urandom_range(NUM_CHANNELS - 1);
      2:       return '1;
      3, 4:    return a & b & c;
      5, 6:    return a | b;
      default: return a;
    endcase
  endfunction

  task automatic run_random_phase(input logic [INC_W-1:0] inc, input int n_items);
    int r;
    set_hop_inc(inc);
    send_cmd(CMD_START, rand_map());
    for (int k = 1; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < 75)      send_cmd(CMD_HOP, rand_map());
      else if (r < 86) send_cmd(CMD_MAP, rand_map());
      else if (r < 94) send_cmd(CMD_START, rand_map());
      else             send_cmd(CMD_UNDEF, rand_map());
    end
    drain();
  endtask

  initial begin
    logic [INC_W-1:0] incs [10];
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_command     <= CMD_HOP;
    in_channel_map <= '0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, empty map, full map, single channels, alternating maps, unknown command
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_HOP, '1);
    send_cmd(CMD_UNDEF, '1);
    send_cmd(CMD_START, '0);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_MAP, '1);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_START, 37'h00_0000_0001);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_MAP, 37'h10_0000_0000);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_MAP, 37'h0A_AAAA_AAAA);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_HOP, '1);
    send_cmd(CMD_UNDEF, '0);
    send_cmd(CMD_START, 37'h15_5555_5555);
    send_cmd(CMD_HOP, '0);
    send_cmd(CMD_MAP, '0);
    send_cmd(CMD_HOP, '0);
    drain();

    // increment sweep: edges of the legal range, zero, out-of-range values and random legal values
    incs[0] = 6'd1;
    incs[1] = 6'd36;
    incs[2] = 6'd0;
    incs[3] = 6'd37;
    incs[4] = 6'd63;
    for (int p = 5; p < 10; p++) incs[p] = INC_W'($urandom_range(36, 1));
    for (int p = 0; p < 10; p++) begin
      gaps_on = (p != 6);
      run_random_phase(incs[p], 85);
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/dchs_pkg.sv
hw/rtl/dchs_ram.sv
hw/rtl/dchs_mod.sv
hw/rtl/dchs_dp.sv
hw/rtl/dchs_ctrl.sv
hw/rtl/data_channel_hop_select.sv
hw/rtl/dchs_chk.sv
test/dchs_sel_checker.sv
test/tb_data_channel_hop_select.sv
